### hdl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int POOL_UNITS_DEF  = 128;
    localparam int FREE_DEPTH_DEF  = 64;
    localparam int ALLOC_DEPTH_DEF = 128;

    localparam logic [7:0] MAX_REQUEST_RST = 8'd16;
    localparam logic [6:0] HOLE_LIMIT_RST  = 7'd2;

    localparam logic CFG_MAX_REQUEST = 1'b0;
    localparam logic CFG_HOLE_LIMIT  = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SIZE    = 2'd1,
        ST_NOFIT   = 2'd2,
        ST_NOOWNER = 2'd3
    } status_t;

    // Per-cycle command to a row of table cells.
    typedef struct packed {
        logic pop;
        logic push;
    } row_ctl_t;

endpackage

### hdl/ffsa_cell.sv
// ----------------------------------------------------------------------------
// ffsa_cell
// One table entry: loads a new value or takes its right neighbor's value.
// ----------------------------------------------------------------------------
module ffsa_cell #(
    parameter int           W         = 14,
    parameter bit           RESET_EN  = 1'b1,
    parameter logic [W-1:0] RESET_VAL = '0
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  logic         shift,
    input  logic [W-1:0] load_data,
    input  logic [W-1:0] right_data,
    output logic [W-1:0] q
);

    logic [W-1:0] data_reg;

    generate
        if (RESET_EN) begin : g_rst
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    data_reg <= RESET_VAL;
                end
                else if (load)
                begin
                    data_reg <= load_data;
                end
                else if (shift)
                begin
                    data_reg <= right_data;
                end
            end
        end
        else begin : g_nrst
            always_ff @(posedge clk)
            begin
                if (load)
                begin
                    data_reg <= load_data;
                end
                else if (shift)
                begin
                    data_reg <= right_data;
                end
            end
        end
    endgenerate

    assign q = data_reg;

endmodule

### hdl/ffsa_row.sv
// ----------------------------------------------------------------------------
// ffsa_row
// Row of cells used as an ordered queue: pop at the head, push at the tail.
// ----------------------------------------------------------------------------
module ffsa_row #(
    parameter int           DEPTH       = 64,
    parameter int           W           = 14,
    parameter bit           RESET_EN    = 1'b1,
    parameter logic [W-1:0] RESET_HEAD  = '0,
    parameter int           RESET_COUNT = 1,
    parameter int           CW          = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ffsa_pkg::row_ctl_t ctl,
    input  logic [W-1:0]      push_data,
    output logic [W-1:0]      head,
    output logic [CW-1:0]     count
);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] widx;
    logic [W-1:0]  cell_q [DEPTH];

    // With a pop in the same cycle the tail slot moves down by one.
    assign widx       = ctl.pop ? (count_reg - CW'(1)) : count_reg;
    assign count_next = count_reg + CW'(ctl.push) - CW'(ctl.pop);

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            ffsa_cell #(
                .W         (W),
                .RESET_EN  (RESET_EN),
                .RESET_VAL (RESET_HEAD)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .load       (ctl.push && (widx == CW'(i))),
                .shift      (ctl.pop),
                .load_data  (push_data),
                .right_data (cell_q[(i < DEPTH - 1) ? i + 1 : i]),
                .q          (cell_q[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CW'(RESET_COUNT);
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head  = cell_q[0];
    assign count = count_reg;

endmodule

### hdl/first_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit allocator with coalescing over a pool of units.
// ----------------------------------------------------------------------------
// Pulse start while busy is low; the result appears for one cycle with done
// high and cannot be held off, so it must be captured then. The work is done
// by the two rows of table cells, which stream one entry per cycle past the
// control at their head, but for a step in which a freed range goes in as a
// new entry between two segments: one pass over the free row for every
// request, and for a deallocate a search pass over the allocation row and,
// when it succeeds, a removal pass over it.
module first_fit_segment_allocator #(
    parameter int POOL_UNITS        = ffsa_pkg::POOL_UNITS_DEF,
    parameter int FREE_TABLE_DEPTH  = ffsa_pkg::FREE_DEPTH_DEF,
    parameter int ALLOC_TABLE_DEPTH = ffsa_pkg::ALLOC_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       operation,
    input  logic [7:0] owner_id,
    input  logic [7:0] unit_count,
    output logic       done,
    output logic [1:0] status,
    output logic [6:0] segment_position,
    output logic [6:0] hole_count,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    import ffsa_pkg::*;

    localparam int AW  = $clog2(POOL_UNITS);
    localparam int AW1 = AW + 1;
    localparam int FW  = 2 * AW;
    localparam int AWD = 2 * AW + 8;
    localparam int FCW = $clog2(FREE_TABLE_DEPTH + 1);
    localparam int ACW = $clog2(ALLOC_TABLE_DEPTH + 1);
    localparam int SW  = (AW + 1 > 8) ? AW + 1 : 8;
    localparam int HCW = (AW > 7) ? AW : 7;
    localparam logic [FW-1:0] FREE_RESET = {AW'(0), AW'(POOL_UNITS - 1)};

    typedef enum logic [1:0] {
        S_IDLE,
        S_ASCAN,
        S_FPASS,
        S_ADROP
    } state_t;

    // Table rows
    row_ctl_t       f_ctl, a_ctl;
    logic [FW-1:0]  fhead, f_push_data;
    logic [FCW-1:0] fcount;
    logic [AWD-1:0] ahead, a_push_data;
    logic [ACW-1:0] acount;

    ffsa_row #(
        .DEPTH       (FREE_TABLE_DEPTH),
        .W           (FW),
        .RESET_EN    (1'b1),
        .RESET_HEAD  (FREE_RESET),
        .RESET_COUNT (1),
        .CW          (FCW)
    ) u_free_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (f_ctl),
        .push_data (f_push_data),
        .head      (fhead),
        .count     (fcount)
    );

    ffsa_row #(
        .DEPTH       (ALLOC_TABLE_DEPTH),
        .W           (AWD),
        .RESET_EN    (1'b0),
        .RESET_HEAD  ('0),
        .RESET_COUNT (0),
        .CW          (ACW)
    ) u_alloc_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (a_ctl),
        .push_data (a_push_data),
        .head      (ahead),
        .count     (acount)
    );

    // Registers
    state_t         state_reg, state_next;
    logic           op_reg, op_next;
    logic [7:0]     owner_reg, owner_next;
    logic [7:0]     units_reg, units_next;
    status_t        status_reg, status_next;
    logic           settled_reg, settled_next;
    logic           full_reg, full_next;
    logic [6:0]     pos_reg, pos_next;
    logic [6:0]     pcnt_reg, pcnt_next;
    logic [6:0]     holes_reg, holes_next;
    logic [FCW-1:0] rem_reg, rem_next;
    logic [FW-1:0]  held_reg, held_next;
    logic           held_v_reg, held_v_next;
    logic [AW-1:0]  st_reg, st_next;
    logic [AW-1:0]  en_reg, en_next;
    logic [ACW-1:0] arem_reg, arem_next;
    logic [ACW-1:0] aidx_reg, aidx_next;
    logic [ACW-1:0] fidx_reg, fidx_next;
    logic           done_reg, done_next;
    logic [7:0]     max_req_reg;
    logic [6:0]     hole_lim_reg;

    // Head-of-row arithmetic
    logic [AW-1:0] hs, he, held_s, held_e;
    logic [SW-1:0] size_w, units_w, hs_plus_w, alloc_end_w;
    logic          fits, exact, after, left_hit, right_hit, push_is_hole;

    assign hs          = fhead[FW-1:AW];
    assign he          = fhead[AW-1:0];
    assign held_s      = held_reg[FW-1:AW];
    assign held_e      = held_reg[AW-1:0];
    assign size_w      = SW'(he) - SW'(hs) + SW'(1);
    assign units_w     = SW'(units_reg);
    assign hs_plus_w   = SW'(hs) + units_w;
    assign alloc_end_w = hs_plus_w - SW'(1);
    assign fits        = size_w >= units_w;
    assign exact       = size_w == units_w;
    assign after       = hs > en_reg;
    assign left_hit    = held_v_reg && ((AW1'(held_e) + AW1'(1)) == AW1'(st_reg));
    assign right_hit   = AW1'(hs) == (AW1'(en_reg) + AW1'(1));
    assign push_is_hole = (HCW'(f_push_data[AW-1:0]) - HCW'(f_push_data[FW-1:AW]))
                          <= HCW'(hole_lim_reg);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        owner_next   = owner_reg;
        units_next   = units_reg;
        status_next  = status_reg;
        settled_next = settled_reg;
        full_next    = full_reg;
        pos_next     = pos_reg;
        pcnt_next    = pcnt_reg;
        holes_next   = holes_reg;
        rem_next     = rem_reg;
        held_next    = held_reg;
        held_v_next  = held_v_reg;
        st_next      = st_reg;
        en_next      = en_reg;
        arem_next    = arem_reg;
        aidx_next    = aidx_reg;
        fidx_next    = fidx_reg;
        done_next    = 1'b0;
        f_ctl        = '0;
        a_ctl        = '0;
        f_push_data  = held_reg;
        a_push_data  = {owner_reg, st_reg, en_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next      = operation;
                    owner_next   = owner_id;
                    units_next   = unit_count;
                    pos_next     = '0;
                    pcnt_next    = '0;
                    holes_next   = '0;
                    held_v_next  = 1'b0;
                    settled_next = 1'b0;
                    full_next    = fcount == FCW'(FREE_TABLE_DEPTH);
                    rem_next     = fcount;
                    status_next  = ST_OK;
                    if (operation == OP_ALLOC)
                    begin
                        // A refused request still walks the free row for the hole count.
                        if ((unit_count == 8'd0) || (unit_count > max_req_reg))
                        begin
                            status_next  = ST_SIZE;
                            settled_next = 1'b1;
                        end
                        else if (acount == ACW'(ALLOC_TABLE_DEPTH))
                        begin
                            status_next  = ST_NOFIT;
                            settled_next = 1'b1;
                        end
                        state_next = S_FPASS;
                    end
                    else
                    begin
                        status_next = ST_NOOWNER;
                        arem_next   = acount;
                        aidx_next   = '0;
                        state_next  = S_ASCAN;
                    end
                end
            end

            S_ASCAN:
            begin
                if (arem_reg == '0)
                begin
                    settled_next = status_reg == ST_NOOWNER;
                    state_next   = S_FPASS;
                end
                else
                begin
                    // Rotate the row once; the last match seen is the newest.
                    a_ctl.pop   = 1'b1;
                    a_ctl.push  = 1'b1;
                    a_push_data = ahead;
                    arem_next   = arem_reg - ACW'(1);
                    aidx_next   = aidx_reg + ACW'(1);
                    if (ahead[AWD-1:FW] == owner_reg)
                    begin
                        status_next = ST_OK;
                        fidx_next   = aidx_reg;
                        st_next     = ahead[FW-1:AW];
                        en_next     = ahead[AW-1:0];
                    end
                end
            end

            S_FPASS:
            begin
                if (rem_reg != '0)
                begin
                    // Each segment passes through the held register before it is
                    // pushed back, so a left neighbor can still be changed.
                    f_ctl.pop   = 1'b1;
                    f_ctl.push  = held_v_reg;
                    held_next   = fhead;
                    held_v_next = 1'b1;
                    rem_next    = rem_reg - FCW'(1);
                    pcnt_next   = pcnt_reg + 7'd1;
                    if (!settled_reg)
                    begin
                        if (op_reg == OP_ALLOC)
                        begin
                            if (fits)
                            begin
                                settled_next = 1'b1;
                                pos_next     = pcnt_reg + 7'd1;
                                st_next      = hs;
                                en_next      = alloc_end_w[AW-1:0];
                                if (exact)
                                begin
                                    held_v_next = 1'b0;
                                end
                                else
                                begin
                                    held_next = {hs_plus_w[AW-1:0], he};
                                end
                            end
                        end
                        else if (after)
                        begin
                            settled_next = 1'b1;
                            if (left_hit && right_hit)
                            begin
                                f_push_data = {held_s, he};
                                held_v_next = 1'b0;
                            end
                            else if (left_hit)
                            begin
                                f_push_data = {held_s, en_reg};
                            end
                            else if (right_hit)
                            begin
                                held_next = {st_reg, he};
                            end
                            else if (full_reg)
                            begin
                                status_next = ST_NOFIT;
                            end
                            else
                            begin
                                // Insert the freed range ahead of this segment,
                                // which is taken on the next cycle.
                                f_ctl.pop = 1'b0;
                                held_next = {st_reg, en_reg};
                                rem_next  = rem_reg;
                                pcnt_next = pcnt_reg;
                            end
                        end
                    end
                end
                else if ((op_reg == OP_FREE) && !settled_reg)
                begin
                    // The freed range lies above every free segment.
                    settled_next = 1'b1;
                    if (left_hit)
                    begin
                        held_next = {held_s, en_reg};
                    end
                    else if (full_reg)
                    begin
                        status_next = ST_NOFIT;
                    end
                    else
                    begin
                        f_ctl.push  = held_v_reg;
                        held_next   = {st_reg, en_reg};
                        held_v_next = 1'b1;
                    end
                end
                else
                begin
                    f_ctl.push  = held_v_reg;
                    held_v_next = 1'b0;
                    if (!settled_reg || (status_reg != ST_OK))
                    begin
                        if (!settled_reg)
                        begin
                            status_next = ST_NOFIT;
                        end
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (op_reg == OP_ALLOC)
                    begin
                        a_ctl.push = 1'b1;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        arem_next  = acount;
                        aidx_next  = '0;
                        state_next = S_ADROP;
                    end
                end
            end

            S_ADROP:
            begin
                if (arem_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    a_ctl.pop   = 1'b1;
                    a_ctl.push  = aidx_reg != fidx_reg;
                    a_push_data = ahead;
                    arem_next   = arem_reg - ACW'(1);
                    aidx_next   = aidx_reg + ACW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (f_ctl.push && push_is_hole)
        begin
            holes_next = holes_reg + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            settled_reg <= 1'b0;
            held_v_reg  <= 1'b0;
            done_reg    <= 1'b0;
            status_reg  <= ST_OK;
            pos_reg     <= '0;
            holes_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            settled_reg <= settled_next;
            held_v_reg  <= held_v_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            pos_reg     <= pos_next;
            holes_reg   <= holes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        owner_reg <= owner_next;
        units_reg <= units_next;
        full_reg  <= full_next;
        pcnt_reg  <= pcnt_next;
        rem_reg   <= rem_next;
        held_reg  <= held_next;
        st_reg    <= st_next;
        en_reg    <= en_next;
        arem_reg  <= arem_next;
        aidx_reg  <= aidx_next;
        fidx_reg  <= fidx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_req_reg  <= MAX_REQUEST_RST;
            hole_lim_reg <= HOLE_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAX_REQUEST: max_req_reg  <= cfg_data;
                CFG_HOLE_LIMIT:  hole_lim_reg <= cfg_data[6:0];
                default:         max_req_reg  <= max_req_reg;
            endcase
        end
    end

    assign busy             = state_reg != S_IDLE;
    assign done             = done_reg;
    assign status           = status_reg;
    assign segment_position = pos_reg;
    assign hole_count       = holes_reg;

    // A result transfer always returns the block to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start");

    a_pos_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (segment_position == 7'd0))
        else $error("position reported on a failed request");

    a_free_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcount <= FCW'(FREE_TABLE_DEPTH))
        else $error("free row overflow");

endmodule

### tb/first_fit_segment_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_tb
// Self-checking bench: a shadow allocator tracks the free and allocation
// tables, predicts status, segment position and hole count for every request
// transfer, and compares each done pulse with the oldest prediction.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_tb;
    import ffsa_pkg::*;

    localparam int POOL   = 128;
    localparam int FDEPTH = 64;
    localparam int ADEPTH = 128;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic       op;
        logic [7:0] owner;
        logic [7:0] units;
    } request_t;

    typedef struct {
        status_t    st;
        logic [6:0] pos;
        logic [6:0] holes;
    } outcome_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       operation;
    logic [7:0] owner_id;
    logic [7:0] unit_count;
    logic       done;
    logic [1:0] status;
    logic [6:0] segment_position;
    logic [6:0] hole_count;
    logic       cfg_write;
    logic       cfg_index;
    logic [7:0] cfg_data;

    first_fit_segment_allocator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .owner_id(owner_id), .unit_count(unit_count),
        .done(done), .status(status), .segment_position(segment_position),
        .hole_count(hole_count), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Shadow state of the allocator.
    int unsigned seg_lo [FDEPTH];
    int unsigned seg_hi [FDEPTH];
    int unsigned seg_used;
    int unsigned blk_lo [ADEPTH];
    int unsigned blk_hi [ADEPTH];
    int unsigned blk_own [ADEPTH];
    int unsigned blk_used;
    int unsigned limit_request;
    int unsigned limit_hole;

    request_t pending_requests [$];
    outcome_t expected_outcomes [$];
    int  errors;
    int  results_seen;
    int  idle_pct;
    int  stall_cycles;

    function automatic int unsigned count_holes();
        int unsigned n;
        n = 0;
        for (int i = 0; i < seg_used; i++)
            if (seg_hi[i] - seg_lo[i] <= limit_hole) n++;
        return n;
    endfunction

    function automatic void drop_segment(int unsigned k);
        for (int unsigned i = k; i + 1 < seg_used; i++)
        begin
            seg_lo[i] = seg_lo[i + 1];
            seg_hi[i] = seg_hi[i + 1];
        end
        seg_used--;
    endfunction

    function automatic outcome_t predict_allocator(request_t r);
        outcome_t o;
        int unsigned sz, k, at, st, en;
        bit found, lft, rgt, hit;
        o.st  = ST_OK;
        o.pos = '0;
        if (r.op == OP_ALLOC) begin
            if (r.units < 1 || r.units > limit_request) o.st = ST_SIZE;
            else if (blk_used >= ADEPTH) o.st = ST_NOFIT;
            else
            begin
                hit = 0;
                for (int unsigned i = 0; i < seg_used && !hit; i++)
                begin
                    sz = seg_hi[i] - seg_lo[i] + 1;
                    if (sz >= r.units)
                    begin
                        hit = 1;
                        blk_lo[blk_used]  = seg_lo[i];
                        blk_hi[blk_used]  = seg_lo[i] + r.units - 1;
                        blk_own[blk_used] = r.owner;
                        blk_used++;
                        if (sz == r.units) drop_segment(i);
                        else seg_lo[i] += r.units;
                        o.pos = 7'(i + 1);
                    end
                end
                if (!hit) o.st = ST_NOFIT;
            end
        end
        else
        begin
            found = 0;
            k = 0;
            for (int unsigned j = blk_used; j > 0 && !found; j--)
                if (blk_own[j - 1] == r.owner)
                begin
                    found = 1;
                    k = j - 1;
                end
            if (!found) o.st = ST_NOOWNER;
            else
            begin
                st = blk_lo[k];
                en = blk_hi[k];
                at = 0;
                while (at < seg_used && seg_lo[at] <= en) at++;
                lft = at > 0 && seg_hi[at - 1] + 1 == st;
                rgt = at < seg_used && seg_lo[at] == en + 1;
                if (lft && rgt)
                begin
                    seg_hi[at - 1] = seg_hi[at];
                    drop_segment(at);
                end
                else if (lft) seg_hi[at - 1] = en;
                else if (rgt) seg_lo[at] = st;
                else if (seg_used >= FDEPTH) o.st = ST_NOFIT;
                else
                begin
                    for (int unsigned i = seg_used; i > at; i--)
                    begin
                        seg_lo[i] = seg_lo[i - 1];
                        seg_hi[i] = seg_hi[i - 1];
                    end
                    seg_lo[at] = st;
                    seg_hi[at] = en;
                    seg_used++;
                end
                if (o.st == ST_OK)
                begin
                    for (int unsigned i = k; i + 1 < blk_used; i++)
                    begin
                        blk_lo[i]  = blk_lo[i + 1];
                        blk_hi[i]  = blk_hi[i + 1];
                        blk_own[i] = blk_own[i + 1];
                    end
                    blk_used--;
                end
            end
        end
        o.holes = 7'(count_holes());
        return o;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: one request transfer per start/!busy edge.
    always @(negedge clk)
    begin
        if (rst_n && !(start && !busy) && start)
            ;
        else if (rst_n)
        begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                start      <= 1'b1;
                operation  <= pending_requests[0].op;
                owner_id   <= pending_requests[0].owner;
                unit_count <= pending_requests[0].units;
            end
            else
                start <= 1'b0;
        end
    end

    // Accept at rising edge; the prediction runs in the same edge so the
    // queue order matches the order of transfers.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            expected_outcomes.push_back(predict_allocator(pending_requests.pop_front()));
            stall_cycles <= 0;
        end
        else if (rst_n && done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_outcomes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result status %0d", $time, status);
            end
            else
            begin
                outcome_t e;
                e = expected_outcomes.pop_front();
                if (status !== e.st)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                end
                if (segment_position !== e.pos)
                begin
                    errors++;
                    $display("%0t: segment_position expected %0d actual %0d",
                             $time, e.pos, segment_position);
                end
                if (hole_count !== e.holes)
                begin
                    errors++;
                    $display("%0t: hole_count expected %0d actual %0d",
                             $time, e.holes, hole_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("first_fit_segment_allocator verification failed");
            $finish;
        end
    end

    task automatic add_request(logic op, int own, int units);
        request_t r;
        r.op    = op;
        r.owner = 8'(own);
        r.units = 8'(units);
        pending_requests.push_back(r);
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_register(logic idx, int value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 8'(value);
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_MAX_REQUEST) limit_request = value & 8'hFF;
        else limit_hole = value & 7'h7F;
    endtask

    // Mostly balanced traffic over a small owner set so frees hit live
    // allocations; a few random owners and sizes act as noise.
    task automatic random_phase(int n, int pct);
        int own;
        idle_pct = pct;
        for (int i = 0; i < n; i++)
        begin
            own = $urandom_range(99) < 85 ? $urandom_range(7) : $urandom_range(255);
            if ($urandom_range(1))
                add_request(OP_FREE, own, $urandom_range(255));
            else if ($urandom_range(9) == 0)
                add_request(OP_ALLOC, own, $urandom_range(255));
            else
                add_request(OP_ALLOC, own, $urandom_range(limit_request > 0 ?
                            (limit_request > 12 ? 12 : limit_request) : 1, 1));
        end
        drain();
    endtask

    initial
    begin
        errors = 0;
        results_seen = 0;
        idle_pct = 0;
        stall_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_ALLOC;
        owner_id = '0;
        unit_count = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_MAX_REQUEST;
        cfg_data = '0;
        seg_lo[0] = 0;
        seg_hi[0] = POOL - 1;
        seg_used = 1;
        blk_used = 0;
        limit_request = MAX_REQUEST_RST;
        limit_hole = HOLE_LIMIT_RST;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: size limits, exact fit, absent owner, coalescing.
        add_request(OP_FREE, 8'hFF, 0);
        add_request(OP_ALLOC, 1, 0);
        add_request(OP_ALLOC, 1, 17);
        add_request(OP_ALLOC, 8'hFF, 255);
        add_request(OP_ALLOC, 1, 16);
        add_request(OP_ALLOC, 2, 1);
        add_request(OP_ALLOC, 3, 3);
        add_request(OP_ALLOC, 0, 16);
        add_request(OP_FREE, 2, 8'hFF);
        add_request(OP_FREE, 0, 0);
        add_request(OP_ALLOC, 4, 1);
        add_request(OP_FREE, 1, 0);
        add_request(OP_FREE, 3, 0);
        add_request(OP_FREE, 4, 0);
        add_request(OP_FREE, 4, 0);
        drain();
        write_register(CFG_MAX_REQUEST, 128);
        write_register(CFG_HOLE_LIMIT, 127);
        add_request(OP_ALLOC, 9, 128);
        add_request(OP_ALLOC, 9, 1);
        add_request(OP_FREE, 9, 0);
        add_request(OP_ALLOC, 9, 129);
        drain();

        // Fragment the pool with one-unit blocks to fill the free table,
        // then free in an order that needs new free entries.
        write_register(CFG_MAX_REQUEST, 1);
        write_register(CFG_HOLE_LIMIT, 0);
        for (int i = 0; i < 128; i++) add_request(OP_ALLOC, i[0] ? 1 : 2, 1);
        add_request(OP_ALLOC, 5, 1);
        for (int i = 0; i < 66; i++) add_request(OP_FREE, 2, 0);
        for (int i = 0; i < 70; i++) add_request(OP_FREE, $urandom_range(2, 1), 0);
        drain();

        write_register(CFG_MAX_REQUEST, 16);
        write_register(CFG_HOLE_LIMIT, 2);
        random_phase(300, 0);
        write_register(CFG_MAX_REQUEST, 0);
        write_register(CFG_HOLE_LIMIT, 1);
        random_phase(40, 14);
        write_register(CFG_MAX_REQUEST, 8);
        write_register(CFG_HOLE_LIMIT, 5);
        random_phase(330, 65);
        write_register(CFG_MAX_REQUEST, 255);
        write_register(CFG_HOLE_LIMIT, 3);
        random_phase(150, 14);
        write_register(CFG_MAX_REQUEST, 4);
        write_register(CFG_HOLE_LIMIT, 0);
        random_phase(200, 0);

        $display("Covered %0d results over eight register settings, size and owner faults,",
                 results_seen);
        $display("exact fits, full tables and coalescing under random start gaps.");
        if (errors == 0 && expected_outcomes.size() == 0)
            $display("first_fit_segment_allocator verification clean");
        else
            $display("first_fit_segment_allocator verification failed");
        $finish;
    end
endmodule
